/* rtl/core/rcpfa_pkg.sv */
// Shared types and codes for the refcounted page-frame allocator.
package rcpfa_pkg;

  localparam int PAGE_W = 15;
  localparam int OPER_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OPER_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_INCREF = 2'd2,
    OP_COW    = 2'd3
  } oper_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOTALLOC = 2'd3
  } stat_t;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

/* rtl/core/rcpfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rcpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rcpfa_alu.sv */
// Shared add/subtract unit with unsigned less-than flag.
module rcpfa_alu #(
  parameter int W = 16
) (
  input  rcpfa_pkg::alu_op_t op,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic [W-1:0]       res,
  output logic               lt
);
  import rcpfa_pkg::*;

  logic [W:0] sum;

  always_comb begin
    case (op)
      ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default: sum = {1'b0, a} - {1'b0, b};
    endcase
  end

  assign res = sum[W-1:0];
  // borrow out of the subtract means a < b
  assign lt  = (op == ALU_SUB) && sum[W];

endmodule

/* rtl/core/refcounted_page_frame_allocator_top.sv */
// Top level of the refcounted page-frame allocator: sequencer, count and free-stack RAMs.
//
// After reset the block sweeps the reference-count RAM to zero, one entry per
// cycle, over all NUM_PAGES entries; in_ready stays low during that pass while
// cfg writes are taken at any time. Then each request steps from accept to the
// next in_ready through idle, check, pool check, execute and respond, with a
// second write step before respond for a cow_copy that hands out a new page,
// since that one writes the count RAM twice through its single write port. One
// add/subtract unit does the range compare, the pool compare and the count
// update in turn. A result waits in the output register until taken; the block
// holds in the respond step while an earlier result is still unread.
module refcounted_page_frame_allocator_top #(
  parameter int NUM_PAGES   = 32768,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rcpfa_pkg::OPER_W-1:0] in_operation,
  input  logic [rcpfa_pkg::PAGE_W-1:0] in_page,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rcpfa_pkg::PAGE_W-1:0] out_page_out,
  output logic [rcpfa_pkg::STAT_W-1:0] out_status,
  output logic                         out_page_released,
  output logic                         out_copy_needed,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rcpfa_pkg::PAGE_W-1:0] cfg_data
);
  import rcpfa_pkg::*;

  localparam int NPW = $clog2(NUM_PAGES);
  localparam int SCW = $clog2(NUM_PAGES + 1);
  localparam int PGW = (NPW < PAGE_W) ? NPW : PAGE_W;
  localparam int AW0 = (NPW > PAGE_W) ? NPW : PAGE_W;
  localparam int AW  = (AW0 > COUNT_WIDTH) ? AW0 : COUNT_WIDTH;
  localparam int RW  = ((NPW + 1) > PAGE_W) ? NPW + 1 : PAGE_W + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_AVAIL = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_WR2   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  oper_t                  op_r, op_nxt;
  logic [PAGE_W-1:0]      page_r, page_nxt;
  logic [PAGE_W-1:0]      first_r;
  logic                   bad_r, bad_nxt;
  logic                   avail_r, avail_nxt;
  logic [SCW-1:0]         stk_cnt_r, stk_cnt_nxt;
  logic [NPW-1:0]         next_r, next_nxt;
  logic                   exh_r, exh_nxt;
  logic [NPW-1:0]         clr_r, clr_nxt;
  logic [COUNT_WIDTH-1:0] dec_r, dec_nxt;

  logic [PAGE_W-1:0]      res_page_r, res_page_nxt;
  stat_t                  res_stat_r, res_stat_nxt;
  logic                   res_rel_r, res_rel_nxt;
  logic                   res_copy_r, res_copy_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]      out_page_r;
  stat_t                  out_stat_r;
  logic                   out_rel_r;
  logic                   out_copy_r;
  logic                   out_load;

  // count RAM
  logic                   cnt_we;
  logic [NPW-1:0]         cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;

  // free-stack RAM
  logic                   stk_we;
  logic [NPW-1:0]         stk_waddr;
  logic [PGW-1:0]         stk_wdata;
  logic [PGW-1:0]         stk_rdata;

  // shared unit
  alu_op_t                alu_op;
  logic [AW-1:0]          alu_a, alu_b, alu_res;
  logic                   alu_lt;

  logic                   c_zero, c_le1, c_max;
  logic                   from_stack, got_ok;
  logic [NPW-1:0]         got;
  logic [COUNT_WIDTH-1:0] c_new;

  rcpfa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_PAGES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (NPW'(page_r)),
    .rdata (cnt_rdata)
  );

  rcpfa_ram #(.WIDTH(PGW), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (NPW'(stk_cnt_r - SCW'(1))),
    .rdata (stk_rdata)
  );

  rcpfa_alu #(.W(AW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // operand select for the shared unit, one use per step
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      S_CHECK: begin
        alu_a = AW'(page_r);
        alu_b = AW'(first_r);
      end
      S_AVAIL: begin
        alu_a = AW'(next_r);
        alu_b = AW'(first_r);
      end
      S_EXEC: begin
        alu_op = (op_r == OP_INCREF) ? ALU_ADD : ALU_SUB;
        alu_a  = AW'(cnt_rdata);
        alu_b  = AW'(1);
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  assign c_zero     = (cnt_rdata == '0);
  assign c_le1      = (cnt_rdata[COUNT_WIDTH-1:1] == '0);
  assign c_max      = (cnt_rdata == '1);
  assign c_new      = alu_res[COUNT_WIDTH-1:0];
  assign from_stack = (stk_cnt_r != '0);
  assign got_ok     = from_stack || avail_r;
  assign got        = from_stack ? NPW'(stk_rdata) : next_r;
  assign out_load   = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    page_nxt     = page_r;
    bad_nxt      = bad_r;
    avail_nxt    = avail_r;
    stk_cnt_nxt  = stk_cnt_r;
    next_nxt     = next_r;
    exh_nxt      = exh_r;
    clr_nxt      = clr_r;
    dec_nxt      = dec_r;
    res_page_nxt = res_page_r;
    res_stat_nxt = res_stat_r;
    res_rel_nxt  = res_rel_r;
    res_copy_nxt = res_copy_r;
    cnt_we       = 1'b0;
    cnt_waddr    = NPW'(page_r);
    cnt_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = NPW'(stk_cnt_r);
    stk_wdata    = PGW'(page_r);

    case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + NPW'(1);
        if (clr_r == NPW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = oper_t'(in_operation);
          page_nxt  = in_page;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        bad_nxt   = alu_lt || (RW'(page_r) >= RW'(NUM_PAGES));
        state_nxt = S_AVAIL;
      end
      S_AVAIL: begin
        avail_nxt = !exh_r && !alu_lt;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_page_nxt = '0;
        res_stat_nxt = ST_OK;
        res_rel_nxt  = 1'b0;
        res_copy_nxt = 1'b0;
        state_nxt    = S_RESP;
        if (op_r == OP_ALLOC || (op_r == OP_COW && !bad_r && !c_le1)) begin
          if (got_ok) begin
            // take a page: stack top first, then the downward counter
            if (from_stack) begin
              stk_cnt_nxt = stk_cnt_r - SCW'(1);
            end else if (next_r == '0) begin
              exh_nxt = 1'b1;
            end else begin
              next_nxt = next_r - NPW'(1);
            end
            cnt_we       = 1'b1;
            cnt_waddr    = got;
            cnt_wdata    = COUNT_WIDTH'(1);
            res_page_nxt = PAGE_W'(got);
            if (op_r == OP_COW) begin
              res_copy_nxt = 1'b1;
              dec_nxt      = c_new;
              state_nxt    = S_WR2;
            end
          end else begin
            res_stat_nxt = ST_OOM;
          end
        end else if (bad_r) begin
          res_stat_nxt = ST_BAD;
        end else begin
          case (op_r)
            OP_FREE: begin
              if (c_zero) begin
                res_stat_nxt = ST_NOTALLOC;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = c_new;
                if (c_new == '0) begin
                  res_rel_nxt = 1'b1;
                  if (stk_cnt_r != SCW'(NUM_PAGES)) begin
                    stk_we      = 1'b1;
                    stk_cnt_nxt = stk_cnt_r + SCW'(1);
                  end
                end
              end
            end
            OP_INCREF: begin
              if (c_zero) begin
                res_stat_nxt = ST_NOTALLOC;
              end else if (!c_max) begin
                cnt_we    = 1'b1;
                cnt_wdata = c_new;
              end
            end
            OP_COW: begin
              // count at most one: keep the page
              res_page_nxt = page_r;
            end
            default: begin
              res_stat_nxt = ST_OK;
            end
          endcase
        end
      end
      S_WR2: begin
        // drop one reference from the original page
        cnt_we    = 1'b1;
        cnt_waddr = NPW'(page_r);
        cnt_wdata = dec_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      first_r     <= '0;
      stk_cnt_r   <= '0;
      next_r      <= NPW'(NUM_PAGES - 1);
      exh_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stk_cnt_r   <= stk_cnt_nxt;
      next_r      <= next_nxt;
      exh_r       <= exh_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        first_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    page_r     <= page_nxt;
    bad_r      <= bad_nxt;
    avail_r    <= avail_nxt;
    dec_r      <= dec_nxt;
    res_page_r <= res_page_nxt;
    res_stat_r <= res_stat_nxt;
    res_rel_r  <= res_rel_nxt;
    res_copy_r <= res_copy_nxt;
    if (out_load) begin
      out_page_r <= res_page_r;
      out_stat_r <= res_stat_r;
      out_rel_r  <= res_rel_r;
      out_copy_r <= res_copy_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_page_out      = out_page_r;
  assign out_status        = out_stat_r;
  assign out_page_released = out_rel_r;
  assign out_copy_needed   = out_copy_r;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the refcounted page-frame allocator.
`timescale 1ns / 1ps

module testbench;
  import rcpfa_pkg::*;

  localparam int NUM_PAGES = 32768;
  localparam int COUNT_W = 8;
  localparam logic [PAGE_W-1:0] TOP_PAGE = PAGE_W'(NUM_PAGES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int SETTLE_CYCLES = 12;
  localparam int HELD_LIMIT = 48;
  localparam int FLOOR_GAP = 40;

  typedef struct packed {
    logic [PAGE_W-1:0] page_out;
    stat_t status;
    logic released;
    logic copy;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPER_W-1:0] in_operation = '0;
  logic [PAGE_W-1:0] in_page = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PAGE_W-1:0] out_page_out;
  logic [STAT_W-1:0] out_status;
  logic out_page_released;
  logic out_copy_needed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [PAGE_W-1:0] cfg_data = '0;

  // Allocator state as predicted from the accepted beats
  logic [PAGE_W-1:0] first_usable;
  logic [PAGE_W-1:0] freed_stack[NUM_PAGES];
  int unsigned stack_depth;
  int unsigned fresh_page;
  bit fresh_spent;
  logic [COUNT_W-1:0] share_count[NUM_PAGES];

  outcome_t awaited_results[$];
  outcome_t last_outcome;
  outcome_t want;
  logic [PAGE_W-1:0] held_pages[$];
  int fail_count = 0;
  bit no_idle = 1'b0;

  refcounted_page_frame_allocator_top #(
    .NUM_PAGES(NUM_PAGES),
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_page(in_page),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_page_out(out_page_out),
    .out_status(out_status),
    .out_page_released(out_page_released),
    .out_copy_needed(out_copy_needed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing pending: page_out %0d status %0d",
               out_page_out, out_status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_page_out !== want.page_out) begin
          $error("page_out: expected %0d, got %0d", want.page_out, out_page_out);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_page_released !== want.released) begin
          $error("page_released: expected %0d, got %0d", want.released,
                 out_page_released);
          fail_count++;
        end
        if (out_copy_needed !== want.copy) begin
          $error("copy_needed: expected %0d, got %0d", want.copy, out_copy_needed);
          fail_count++;
        end
      end
    end
  end

  // Pop the free stack first, then the downward counter of untouched pages
  function automatic bit grab_page(output logic [PAGE_W-1:0] got);
    got = '0;
    if (stack_depth > 0) begin
      stack_depth--;
      got = freed_stack[stack_depth];
    end else if (!fresh_spent && fresh_page >= first_usable) begin
      got = fresh_page[PAGE_W-1:0];
      if (fresh_page == 0) fresh_spent = 1'b1;
      else fresh_page--;
    end else begin
      return 1'b0;
    end
    share_count[got] = COUNT_W'(1);
    return 1'b1;
  endfunction

  function automatic outcome_t predict_outcome(input oper_t op, input logic [PAGE_W-1:0] pg);
    outcome_t res;
    logic [COUNT_W-1:0] cnt;
    logic [PAGE_W-1:0] got;
    res.page_out = '0;
    res.status = ST_OK;
    res.released = 1'b0;
    res.copy = 1'b0;
    if (op == OP_ALLOC) begin
      if (grab_page(got)) res.page_out = got;
      else res.status = ST_OOM;
    end else if (pg < first_usable) begin
      res.status = ST_BAD;
    end else begin
      cnt = share_count[pg];
      case (op)
        OP_FREE: begin
          if (cnt == 0) begin
            res.status = ST_NOTALLOC;
          end else begin
            cnt--;
            share_count[pg] = cnt;
            if (cnt == 0) begin
              if (stack_depth < NUM_PAGES) begin
                freed_stack[stack_depth] = pg;
                stack_depth++;
              end
              res.released = 1'b1;
            end
          end
        end
        OP_INCREF: begin
          if (cnt == 0) res.status = ST_NOTALLOC;
          else if (cnt != COUNT_MAX) share_count[pg] = cnt + 1'b1;
        end
        default: begin
          // Sole or unowned page stays in place; shared page gets a private copy
          if (cnt <= 1) begin
            res.page_out = pg;
          end else if (grab_page(got)) begin
            share_count[pg] = cnt - 1'b1;
            res.page_out = got;
            res.copy = 1'b1;
          end else begin
            res.status = ST_OOM;
          end
        end
      endcase
    end
    return res;
  endfunction

  task automatic send_request(input oper_t op, input logic [PAGE_W-1:0] pg);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_page <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_outcome = predict_outcome(op, pg);
    awaited_results.push_back(last_outcome);
    if (last_outcome.status == ST_OK && (op == OP_ALLOC || op == OP_COW)) begin
      held_pages.push_back(last_outcome.page_out);
      if (held_pages.size() > HELD_LIMIT) void'(held_pages.pop_front());
    end
  endtask

  // Drop valid and hold until every pending result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_first_usable(input logic [PAGE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    first_usable = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70 && held_pages.size() > 0) return held_pages[$urandom_range(held_pages.size() - 1)];
    if (r < 80) begin
      case ($urandom_range(2))
        0: return (first_usable == 0) ? first_usable : first_usable - 1'b1;
        1: return first_usable;
        default: return TOP_PAGE;
      endcase
    end
    return PAGE_W'($urandom_range(NUM_PAGES - 1));
  endfunction

  task automatic run_mix(input int count, input int alloc_pct);
    oper_t op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        case ($urandom_range(2))
          0: op = OP_FREE;
          1: op = OP_INCREF;
          default: op = OP_COW;
        endcase
      end
      send_request(op, pick_page());
      if ($urandom_range(149) == 0) drain_results();
    end
  endtask

  task automatic test_basic_ops();
    set_first_usable('0);
    send_request(OP_FREE, 15'd5);
    send_request(OP_INCREF, 15'd5);
    send_request(OP_COW, 15'd5);
    send_request(OP_ALLOC, 15'd0);
    send_request(OP_INCREF, TOP_PAGE);
    send_request(OP_COW, TOP_PAGE);
    send_request(OP_COW, TOP_PAGE);
    send_request(OP_FREE, TOP_PAGE - 1'b1);
    send_request(OP_ALLOC, TOP_PAGE);
    send_request(OP_FREE, TOP_PAGE);
    send_request(OP_FREE, TOP_PAGE);
    send_request(OP_FREE, TOP_PAGE - 1'b1);
    send_request(OP_INCREF, TOP_PAGE);
  endtask

  // Free stack now holds the top two pages; raise the floor above one of them
  task automatic test_first_usable_limits();
    drain_results();
    set_first_usable(TOP_PAGE);
    send_request(OP_FREE, 15'd0);
    send_request(OP_INCREF, TOP_PAGE - 1'b1);
    send_request(OP_COW, 15'd12345);
    send_request(OP_ALLOC, 15'd0);
    send_request(OP_ALLOC, 15'd0);
    send_request(OP_ALLOC, 15'd0);
    send_request(OP_INCREF, TOP_PAGE);
    send_request(OP_COW, TOP_PAGE);
    send_request(OP_FREE, TOP_PAGE);
    send_request(OP_COW, TOP_PAGE);
    drain_results();
    set_first_usable('0);
    send_request(OP_ALLOC, TOP_PAGE);
  endtask

  task automatic test_count_saturation();
    logic [PAGE_W-1:0] pg;
    send_request(OP_ALLOC, '0);
    pg = last_outcome.page_out;
    repeat (int'(COUNT_MAX) + 1) send_request(OP_INCREF, pg);
    send_request(OP_COW, pg);
    send_request(OP_FREE, last_outcome.page_out);
    send_request(OP_FREE, pg);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: set_first_usable(PAGE_W'(NUM_PAGES - 68));
        1: set_first_usable(PAGE_W'($urandom_range(1, NUM_PAGES - 2)));
        2: set_first_usable('0);
        default: set_first_usable(TOP_PAGE);
      endcase
      no_idle = (ph == 2);
      run_mix(260, (ph == 0) ? 45 : 30);
    end
    no_idle = 1'b0;
  endtask

  // Run the counter down to a floor just below it, then live off the free stack
  task automatic test_pool_exhaustion();
    int guard;
    drain_results();
    if (fresh_spent || fresh_page < FLOOR_GAP) set_first_usable('0);
    else set_first_usable(PAGE_W'(fresh_page - FLOOR_GAP));
    guard = 0;
    do begin
      send_request(OP_ALLOC, PAGE_W'($urandom_range(NUM_PAGES - 1)));
      guard++;
    end while (last_outcome.status != ST_OOM && guard < NUM_PAGES + 64);
    for (int i = 0; i < 6; i++) send_request(OP_FREE, held_pages[i]);
    repeat (7) send_request(OP_ALLOC, '0);
    send_request(OP_INCREF, held_pages[$]);
    send_request(OP_COW, held_pages[$]);
    run_mix(60, 30);
  endtask

  initial begin
    foreach (share_count[i]) share_count[i] = '0;
    first_usable = '0;
    stack_depth = 0;
    fresh_page = NUM_PAGES - 1;
    fresh_spent = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_first_usable_limits();
    test_count_saturation();
    test_random_traffic();
    test_pool_exhaustion();
    drain_results();

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
